// ===== rtl/core/pkst_pkg.sv =====
// Package with the shared constants and types of the paged knob soft-takeover block.
package pkst_pkg;

   // Number of physical knobs; the request and response channels carry one field per knob.
   localparam int KNOBS = 4;

   // Width and reset value of the pickup threshold register.
   localparam int          THRESH_BITS  = 10;
   localparam logic [9:0]  THRESH_RESET = 10'd5;

   // Widths of the page and LED mask fields on the response channel.
   localparam int PAGE_BITS = 2;
   localparam int MASK_BITS = 4;

   // Stored value preset at reset for one knob on one page; all others reset to zero.
   localparam int          FILL_PAGE  = 1;
   localparam int          FILL_KNOB  = 2;
   localparam logic [15:0] FILL_VALUE = 16'd1023;

   // Bit mask of the knobs that are active.
   typedef logic [KNOBS-1:0] knob_mask_type;

endpackage

// ===== rtl/core/pkst_chan_if.sv =====
// Request and response channel interfaces of the paged knob soft-takeover block.
interface pkst_req_if #(
   parameter int VALUE_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic                  page_press;
   logic                  arp_on;
   logic [VALUE_BITS-1:0] knob_0;
   logic [VALUE_BITS-1:0] knob_1;
   logic [VALUE_BITS-1:0] knob_2;
   logic [VALUE_BITS-1:0] knob_3;

   modport source (
      output valid, page_press, arp_on, knob_0, knob_1, knob_2, knob_3,
      input  ready
   );
   modport sink (
      input  valid, page_press, arp_on, knob_0, knob_1, knob_2, knob_3,
      output ready
   );
endinterface

interface pkst_rsp_if #(
   parameter int VALUE_BITS = 10
);
   logic                               valid;
   logic                               ready;
   logic [pkst_pkg::PAGE_BITS-1:0]     page;
   logic [pkst_pkg::MASK_BITS-1:0]     led_mask;
   logic [VALUE_BITS-1:0]              stored_0;
   logic [VALUE_BITS-1:0]              stored_1;
   logic [VALUE_BITS-1:0]              stored_2;
   logic [VALUE_BITS-1:0]              stored_3;

   modport source (
      output valid, page, led_mask, stored_0, stored_1, stored_2, stored_3,
      input  ready
   );
   modport sink (
      input  valid, page, led_mask, stored_0, stored_1, stored_2, stored_3,
      output ready
   );
endinterface

// ===== rtl/core/paged_knob_soft_takeover.sv =====
// Top level of the paged knob store with soft takeover.
//
// Usage:
//    req_chan carries one knob scan per request: a page-button press flag, the
//    arpeggiator enable and four knob readings. rsp_chan returns one response per
//    request: the page after the scan, the mask of active knobs for the LEDs and
//    the four stored values of that page. csr_wr_en/csr_wr_data write the pickup
//    threshold; write it only while no request is in flight.
// Timing:
//    A response is valid in the cycle after its request is accepted. A new request is
//    accepted every cycle unless a response waits on rsp_chan.ready; the page update,
//    store row read, the four difference compares and the store write all happen in
//    the single accepting cycle, and the response register holds the result.
// Reset:
//    Synchronous, active high. Page 0, all knobs active, threshold 5, all stored
//    values zero except page 1 knob 2, which holds the full-scale value.
// Stall:
//    While a response waits with rsp_chan.ready low, req_chan.ready is low; when
//    the response is taken, the next request is accepted in the same cycle.
module paged_knob_soft_takeover #(
   parameter int PAGES      = 4,
   parameter int VALUE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   pkst_req_if.sink                            req_chan,
   pkst_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [pkst_pkg::THRESH_BITS-1:0]    csr_wr_data
);

   localparam int KNOBS     = pkst_pkg::KNOBS;
   localparam int PW        = $clog2(PAGES);
   localparam int CMP_BITS  = (VALUE_BITS > pkst_pkg::THRESH_BITS) ?
                              VALUE_BITS : pkst_pkg::THRESH_BITS;

   // State registers.
   logic [VALUE_BITS-1:0]            store_ff [PAGES][KNOBS];
   pkst_pkg::knob_mask_type          active_ff;
   pkst_pkg::knob_mask_type          active_in;
   logic [PW-1:0]                    page_ff;
   logic [PW-1:0]                    page_in;
   logic [pkst_pkg::THRESH_BITS-1:0] thresh_ff;

   // Response registers.
   logic                             rsp_valid_ff;
   logic [pkst_pkg::PAGE_BITS-1:0]   rsp_page_ff;
   pkst_pkg::knob_mask_type          rsp_mask_ff;
   logic [VALUE_BITS-1:0]            rsp_stored_ff [KNOBS];
   logic [VALUE_BITS-1:0]            rsp_stored_in [KNOBS];

   logic                             accept;
   logic [VALUE_BITS-1:0]            reading [KNOBS];
   logic [PW:0]                      page_inc;
   logic [PW:0]                      page_limit;

   // Handshake: a new request enters whenever the response register is free or being taken.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign reading[0] = req_chan.knob_0;
   assign reading[1] = req_chan.knob_1;
   assign reading[2] = req_chan.knob_2;
   assign reading[3] = req_chan.knob_3;

   // Page advance: wrap after the last page when the arpeggiator is on, one earlier when off.
   assign page_inc   = {1'b0, page_ff} + (PW+1)'(1);
   assign page_limit = req_chan.arp_on ? (PW+1)'(PAGES) : (PW+1)'(PAGES - 1);

   always_comb begin
      page_in = page_ff;
      if (req_chan.page_press) begin
         page_in = (page_inc >= page_limit) ? '0 : page_inc[PW-1:0];
      end
   end

   // Pickup compare per knob against the stored value of the new page.
   always_comb begin
      logic [VALUE_BITS-1:0] stored;
      logic [VALUE_BITS-1:0] diff;
      active_in = req_chan.page_press ? '0 : active_ff;
      for (int k = 0; k < KNOBS; k++) begin
         stored = store_ff[page_in][k];
         diff   = (reading[k] >= stored) ? (reading[k] - stored) : (stored - reading[k]);
         if (CMP_BITS'(diff) < CMP_BITS'(thresh_ff)) begin
            active_in[k] = 1'b1;
         end
         rsp_stored_in[k] = active_in[k] ? reading[k] : stored;
      end
   end

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= pkst_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // Page and active-mask registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff   <= '0;
         active_ff <= '1;
      end else if (accept) begin
         page_ff   <= page_in;
         active_ff <= active_in;
      end
   end

   // Stored values: active knobs write their reading into the current page.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PAGES; p++) begin
            for (int k = 0; k < KNOBS; k++) begin
               if (p == pkst_pkg::FILL_PAGE && k == pkst_pkg::FILL_KNOB) begin
                  store_ff[p][k] <= VALUE_BITS'(pkst_pkg::FILL_VALUE);
               end else begin
                  store_ff[p][k] <= '0;
               end
            end
         end
      end else if (accept) begin
         for (int k = 0; k < KNOBS; k++) begin
            if (active_in[k]) begin
               store_ff[page_in][k] <= reading[k];
            end
         end
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_page_ff   <= pkst_pkg::PAGE_BITS'(page_in);
         rsp_mask_ff   <= active_in;
         rsp_stored_ff <= rsp_stored_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.page     = rsp_page_ff;
   assign rsp_chan.led_mask = pkst_pkg::MASK_BITS'(rsp_mask_ff);
   assign rsp_chan.stored_0 = rsp_stored_ff[0];
   assign rsp_chan.stored_1 = rsp_stored_ff[1];
   assign rsp_chan.stored_2 = rsp_stored_ff[2];
   assign rsp_chan.stored_3 = rsp_stored_ff[3];

`ifndef SYNTHESIS
   // The page never leaves the configured range.
   a_page_range: assert property (@(posedge clock) disable iff (reset)
      (PW+1)'(page_ff) < (PW+1)'(PAGES))
      else $error("page index out of range");

   // Without a press, knobs that were active stay active.
   a_active_keep: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.page_press) |=> ((active_ff & $past(active_ff)) == $past(active_ff)))
      else $error("active knob lost without a page press");

   // State changes only when a request is accepted.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(page_ff) && $stable(active_ff)))
      else $error("state changed without a request");

   // A pending response shows the current active mask.
   a_mask_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mask_ff == active_ff))
      else $error("response mask differs from active state");
`endif

endmodule

// ===== verif/pkst_checker.sv =====
// Checker that predicts and compares every response of the paged knob soft-takeover block.
module pkst_checker #(
   parameter int PAGES      = 4,
   parameter int VALUE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   pkst_req_if                              req_mon,
   pkst_rsp_if                              rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [pkst_pkg::THRESH_BITS-1:0] csr_wr_data,
   output int                               error_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [VALUE_BITS-1:0] knob_value_type;

   // What one response should show: page, LED mask and the stored row of that page.
   typedef struct packed {
      logic [pkst_pkg::PAGE_BITS-1:0]           page;
      pkst_pkg::knob_mask_type                  led_mask;
      logic [pkst_pkg::KNOBS-1:0][VALUE_BITS-1:0] stored;
   } knob_view_type;

   // Shadow copy of the block's state and threshold.
   knob_value_type                    stored_values [PAGES][pkst_pkg::KNOBS];
   pkst_pkg::knob_mask_type           active_knobs;
   logic [pkst_pkg::PAGE_BITS-1:0]    shadow_page;
   logic [pkst_pkg::THRESH_BITS-1:0]  pickup_level;
   knob_view_type                     expected_views [$];
   int                                mismatch_total = 0;

   // Power-on state: everything zero but the one preset slot, all knobs active.
   function automatic void restore_power_on();
      for (int p = 0; p < PAGES; p++) begin
         for (int k = 0; k < pkst_pkg::KNOBS; k++) begin
            stored_values[p][k] = '0;
         end
      end
      stored_values[pkst_pkg::FILL_PAGE][pkst_pkg::FILL_KNOB] =
         pkst_pkg::FILL_VALUE[VALUE_BITS-1:0];
      active_knobs = '1;
      shadow_page  = '0;
      pickup_level = pkst_pkg::THRESH_RESET;
   endfunction

   // Applies one knob scan to the shadow state and returns the view it leaves.
   function automatic knob_view_type take_scan(input logic press, input logic arp,
      input logic [pkst_pkg::KNOBS-1:0][VALUE_BITS-1:0] reading);
      knob_view_type view;
      int            next_page;
      int            wrap_at;
      int            gap;
      if (press) begin
         wrap_at   = arp ? PAGES : PAGES - 1;
         next_page = int'(shadow_page) + 1;
         if (next_page >= wrap_at) begin
            next_page = 0;
         end
         shadow_page  = next_page[pkst_pkg::PAGE_BITS-1:0];
         active_knobs = '0;
      end
      // A protected knob picks up when it comes close to its stored value.
      for (int k = 0; k < pkst_pkg::KNOBS; k++) begin
         if (int'(reading[k]) >= int'(stored_values[shadow_page][k])) begin
            gap = int'(reading[k]) - int'(stored_values[shadow_page][k]);
         end else begin
            gap = int'(stored_values[shadow_page][k]) - int'(reading[k]);
         end
         if (gap < int'(pickup_level)) begin
            active_knobs[k] = 1'b1;
         end
         if (active_knobs[k]) begin
            stored_values[shadow_page][k] = reading[k];
         end
      end
      view.page     = shadow_page;
      view.led_mask = active_knobs;
      for (int k = 0; k < pkst_pkg::KNOBS; k++) begin
         view.stored[k] = stored_values[shadow_page][k];
      end
      return view;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   // Requests are predicted before responses are compared, so any latency works.
   always @(posedge clock) begin
      knob_view_type                              seen;
      knob_view_type                              want;
      logic [pkst_pkg::KNOBS-1:0][VALUE_BITS-1:0] reading;
      if (reset) begin
         restore_power_on();
         expected_views.delete();
      end else begin
         if (csr_wr_en) begin
            pickup_level = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            reading = {req_mon.knob_3, req_mon.knob_2, req_mon.knob_1, req_mon.knob_0};
            expected_views.push_back(take_scan(req_mon.page_press, req_mon.arp_on, reading));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.page     = rsp_mon.page;
            seen.led_mask = rsp_mon.led_mask;
            seen.stored   = {rsp_mon.stored_3, rsp_mon.stored_2,
                             rsp_mon.stored_1, rsp_mon.stored_0};
            if (expected_views.size() == 0) begin
               $error("Response arrived with no request outstanding");
               mismatch_total++;
            end else begin
               want = expected_views.pop_front();
               compare_field("page", want.page, seen.page);
               compare_field("led_mask", want.led_mask, seen.led_mask);
               for (int k = 0; k < pkst_pkg::KNOBS; k++) begin
                  compare_field($sformatf("stored_%0d", k), want.stored[k], seen.stored[k]);
               end
            end
         end
      end
      pending_count <= expected_views.size();
      error_count   <= mismatch_total;
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the testbench: clock, reset, request stimulus, response pacing and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES           = 4;
   localparam int VALUE_BITS      = 10;
   localparam int PHASE_COUNT     = 7;
   localparam int SCANS_PER_PHASE = 265;
   localparam int IDLE_LIMIT      = 1000;

   typedef struct packed {
      logic                                       page_press;
      logic                                       arp_on;
      logic [pkst_pkg::KNOBS-1:0][VALUE_BITS-1:0] knob;
   } knob_scan_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [pkst_pkg::THRESH_BITS-1:0] csr_wr_data;
   int                               checker_errors;
   int                               checker_pending;

   // Knob positions wander between scans; the arpeggiator flag changes rarely.
   logic [VALUE_BITS-1:0]  knob_pos [pkst_pkg::KNOBS];
   logic                   arp_state;
   int                     calm_scans;

   pkst_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   pkst_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_chan ();

   paged_knob_soft_takeover #(
      .PAGES      (PAGES),
      .VALUE_BITS (VALUE_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pkst_checker #(
      .PAGES      (PAGES),
      .VALUE_BITS (VALUE_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (checker_errors),
      .pending_count (checker_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic knob_scan_type pack_scan(input bit press, input bit arp,
                                               input int k0, input int k1,
                                               input int k2, input int k3);
      knob_scan_type scan;
      scan.page_press = press;
      scan.arp_on     = arp;
      scan.knob[0]    = k0[VALUE_BITS-1:0];
      scan.knob[1]    = k1[VALUE_BITS-1:0];
      scan.knob[2]    = k2[VALUE_BITS-1:0];
      scan.knob[3]    = k3[VALUE_BITS-1:0];
      return scan;
   endfunction

   // Knobs mostly drift in small steps so protected knobs cross their stored
   // values; some readings jump to random values or to the ends of the range.
   function automatic knob_scan_type wander_scan();
      knob_scan_type scan;
      int            roll;
      int            pos;
      if ($urandom_range(0, 99) < 3) begin
         arp_state = ~arp_state;
      end
      scan.page_press = ($urandom_range(0, 99) < 6);
      scan.arp_on     = arp_state;
      for (int k = 0; k < pkst_pkg::KNOBS; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            knob_pos[k] = VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
         end else if (roll < 11) begin
            knob_pos[k] = roll[0] ? '1 : '0;
         end else begin
            pos = int'(knob_pos[k]) + int'($urandom_range(0, 6)) - 3;
            if (pos < 0) begin
               pos = 0;
            end else if (pos > (1 << VALUE_BITS) - 1) begin
               pos = (1 << VALUE_BITS) - 1;
            end
            knob_pos[k] = pos[VALUE_BITS-1:0];
         end
         scan.knob[k] = knob_pos[k];
      end
      return scan;
   endfunction

   // Offers one request after a random gap and returns once it is accepted.
   task automatic send_scan(input knob_scan_type scan);
      int gap;
      if (calm_scans > 0) begin
         gap = 0;
         calm_scans--;
      end else begin
         gap = idle_cycles();
         if ($urandom_range(0, 199) == 0) begin
            calm_scans = $urandom_range(40, 120);
         end
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.page_press <= scan.page_press;
      req_chan.arp_on     <= scan.arp_on;
      req_chan.knob_0     <= scan.knob[0];
      req_chan.knob_1     <= scan.knob[1];
      req_chan.knob_2     <= scan.knob[2];
      req_chan.knob_3     <= scan.knob[3];
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   // Stops requests, lets every response drain, then writes the threshold.
   task automatic write_threshold(input logic [pkst_pkg::THRESH_BITS-1:0] level);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (checker_pending != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Response side: random stalls with occasional long stretches of ready.
   initial begin : rsp_pacing
      int stall;
      int hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         hold = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
         repeat (hold) @(posedge clock);
      end
   end

   // Ends the run when neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [pkst_pkg::THRESH_BITS-1:0] level;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.page_press <= 1'b0;
      req_chan.arp_on     <= 1'b0;
      req_chan.knob_0     <= '0;
      req_chan.knob_1     <= '0;
      req_chan.knob_2     <= '0;
      req_chan.knob_3     <= '0;
      arp_state  = 1'b0;
      calm_scans = 0;
      for (int k = 0; k < pkst_pkg::KNOBS; k++) begin
         knob_pos[k] = VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed scans at the reset threshold: all knobs active after reset,
      // full-scale readings, pickup just inside and just outside the threshold.
      send_scan(pack_scan(0, 0, 0, 0, 0, 0));
      send_scan(pack_scan(0, 1, 1023, 1023, 1023, 1023));
      send_scan(pack_scan(1, 0, 1023, 1023, 1023, 1023));
      send_scan(pack_scan(0, 0, 4, 5, 1020, 1018));
      send_scan(pack_scan(0, 0, 4, 4, 1020, 6));
      send_scan(pack_scan(1, 0, 0, 1, 2, 3));
      // Third press with the arpeggiator off wraps to page 0.
      send_scan(pack_scan(1, 0, 512, 512, 512, 512));
      send_scan(pack_scan(0, 0, 1019, 1018, 1023, 0));
      // Up to the last page with the arpeggiator on, then turn it off there.
      send_scan(pack_scan(1, 1, 700, 300, 1023, 0));
      send_scan(pack_scan(1, 1, 0, 1023, 0, 1023));
      send_scan(pack_scan(1, 1, 3, 2, 1, 0));
      send_scan(pack_scan(0, 0, 9, 8, 7, 6));
      send_scan(pack_scan(0, 1, 1023, 0, 1023, 0));
      send_scan(pack_scan(1, 0, 1023, 1023, 0, 0));
      // Full loop of four pages, wrapping from the last page.
      send_scan(pack_scan(1, 1, 100, 200, 300, 400));
      send_scan(pack_scan(1, 1, 0, 0, 0, 0));
      send_scan(pack_scan(1, 1, 682, 341, 1023, 0));
      send_scan(pack_scan(1, 1, 1022, 1, 1021, 2));
      send_scan(pack_scan(0, 1, 1018, 5, 1017, 6));

      // Random phases, each with its own threshold, the extremes among them.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               level = 10'd1;
            end
            1: begin
               level = '1;
            end
            2: begin
               level = '0;
            end
            3: begin
               level = pkst_pkg::THRESH_RESET;
            end
            5: begin
               level = 10'd64;
            end
            default: begin
               level = pkst_pkg::THRESH_BITS'($urandom_range(0,
                          (1 << pkst_pkg::THRESH_BITS) - 1));
            end
         endcase
         write_threshold(level);
         repeat (SCANS_PER_PHASE) send_scan(wander_scan());
      end

      // Drain and give the verdict.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (checker_pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (checker_errors == 0 && checker_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
